// File: design/spq_pkg.sv
package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VALUE_BITS_DEF = 16;
  localparam int PRIORITY_BITS_DEF = 8;

  localparam int CMD_W = 2;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHANGE  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic ins;
    logic rem;
  } op_t;

endpackage

// File: design/sorted_priority_queue.sv
// the accepted command is registered as the pending word; its result word is registered once
// the output is free; change priority makes a remove pass and, if found, an insert pass
// throughput: 1 word per cycle for enqueue and dequeue while the output is not stalled,
// set by the single broadcast pass per cycle; change priority stalls input until done
// reset: synchronous, clears the entry count, the pending word and the output;
// cell contents are not cleared
module sorted_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = spq_pkg::VALUE_BITS_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int IN_W = ((VALUE_BITS + PRIORITY_BITS + 7) / 8) * 8,
  localparam int OUT_USED = 2 * VALUE_BITS + CNT_W + 1,
  localparam int OUT_W = ((OUT_USED + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // item_value, item_priority
  input  logic [IN_W-1:0]                s_tdata,
  // cmd
  input  logic [spq_pkg::CMD_W-1:0]      s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // removed_value, head_value, entry_count, queue_empty
  output logic [OUT_W-1:0]               m_tdata,
  // status
  output logic [spq_pkg::STATUS_W-1:0]   m_tuser
);
  import spq_pkg::*;

  localparam logic S_FIRST = 1'b0;
  localparam logic S_REINSERT = 1'b1;

  logic                     pend_valid;
  logic [CMD_W-1:0]         pend_cmd;
  logic [VALUE_BITS-1:0]    pend_value;
  logic [PRIORITY_BITS-1:0] pend_priority;

  logic             state, state_next;
  logic [CNT_W-1:0] count, count_next;

  logic [VALUE_BITS-1:0] removed_value, head_value, head_cand;
  logic [CNT_W-1:0]      entry_count;
  logic                  queue_empty;

  logic                  go, finish, head_force, in_accept;
  op_t                   op;
  logic [STATUS_W-1:0]   status_next;
  logic [VALUE_BITS-1:0] removed_next;

  logic [VALUE_BITS-1:0]    cell_value [DEPTH];
  logic [PRIORITY_BITS-1:0] cell_priority [DEPTH];
  logic [DEPTH-1:0]         cell_valid, cell_ge, cell_hit;

  assign go = pend_valid && (!m_tvalid || m_tready);
  assign s_tready = !pend_valid || (go && finish);
  assign in_accept = s_tvalid && s_tready;

  always_comb begin
    op = '0;
    finish = 1'b0;
    head_force = 1'b0;
    status_next = STATUS_OK;
    removed_next = '0;
    count_next = count;
    state_next = state;
    if (go) begin
      case (pend_cmd)
        CMD_ENQUEUE: begin
          finish = 1'b1;
          if (count == CNT_W'(DEPTH)) begin
            status_next = STATUS_FULL;
          end else begin
            op.ins = 1'b1;
            count_next = count + 1'b1;
          end
        end
        CMD_DEQUEUE: begin
          finish = 1'b1;
          if (count == '0) begin
            status_next = STATUS_EMPTY;
          end else begin
            op.rem = 1'b1;
            head_force = 1'b1;
            removed_next = cell_value[0];
            count_next = count - 1'b1;
          end
        end
        CMD_CHANGE: begin
          if (state == S_FIRST) begin
            op.rem = 1'b1;
            if (cell_hit[DEPTH-1]) begin
              count_next = count - 1'b1;
              state_next = S_REINSERT;
            end else begin
              finish = 1'b1;
              status_next = STATUS_NOT_FOUND;
            end
          end else begin
            op.ins = 1'b1;
            count_next = count + 1'b1;
            finish = 1'b1;
            state_next = S_FIRST;
          end
        end
        default: begin
          finish = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    if (op.ins) begin
      head_cand = cell_ge[0] ? cell_value[0] : pend_value;
    end else if (op.rem) begin
      head_cand = cell_hit[0] ? cell_value[1] : cell_value[0];
    end else begin
      head_cand = cell_value[0];
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_BITS-1:0]    pv, nv;
      logic [PRIORITY_BITS-1:0] pp, np;
      logic                     pge, hin;

      assign cell_valid[i] = count > CNT_W'(i);

      if (i == 0) begin : g_first
        assign pv = '0;
        assign pp = '0;
        assign pge = 1'b1;
        assign hin = head_force;
      end else begin : g_mid
        assign pv = cell_value[i-1];
        assign pp = cell_priority[i-1];
        assign pge = cell_ge[i-1];
        assign hin = cell_hit[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign nv = '0;
        assign np = '0;
      end else begin : g_inner
        assign nv = cell_value[i+1];
        assign np = cell_priority[i+1];
      end

      spq_cell #(
        .VALUE_BITS(VALUE_BITS),
        .PRIORITY_BITS(PRIORITY_BITS)
      ) u_cell (
        .clk(clk),
        .op(op),
        .new_value(pend_value),
        .new_priority(pend_priority),
        .valid(cell_valid[i]),
        .prev_value(pv),
        .prev_priority(pp),
        .next_value(nv),
        .next_priority(np),
        .prev_ge(pge),
        .hit_in(hin),
        .value(cell_value[i]),
        .prio(cell_priority[i]),
        .ge(cell_ge[i]),
        .hit_out(cell_hit[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      m_tvalid <= 1'b0;
      count <= '0;
      state <= S_FIRST;
    end else begin
      count <= count_next;
      state <= state_next;
      if (in_accept) begin
        pend_valid <= 1'b1;
      end else if (go && finish) begin
        pend_valid <= 1'b0;
      end
      if (go && finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pend_cmd <= s_tuser;
      pend_value <= s_tdata[VALUE_BITS-1:0];
      pend_priority <= s_tdata[VALUE_BITS +: PRIORITY_BITS];
    end
    if (go && finish) begin
      removed_value <= removed_next;
      head_value <= (count_next != '0) ? head_cand : '0;
      entry_count <= count_next;
      queue_empty <= (count_next == '0);
      m_tuser <= status_next;
    end
  end

  assign m_tdata = {{(OUT_W - OUT_USED){1'b0}}, queue_empty, entry_count, head_value,
                    removed_value};

endmodule

// File: design/spq_cell.sv
module spq_cell #(
  parameter int VALUE_BITS = spq_pkg::VALUE_BITS_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                     clk,
  input  spq_pkg::op_t             op,
  input  logic [VALUE_BITS-1:0]    new_value,
  input  logic [PRIORITY_BITS-1:0] new_priority,
  input  logic                     valid,
  input  logic [VALUE_BITS-1:0]    prev_value,
  input  logic [PRIORITY_BITS-1:0] prev_priority,
  input  logic [VALUE_BITS-1:0]    next_value,
  input  logic [PRIORITY_BITS-1:0] next_priority,
  input  logic                     prev_ge,
  input  logic                     hit_in,
  output logic [VALUE_BITS-1:0]    value,
  output logic [PRIORITY_BITS-1:0] prio,
  output logic                     ge,
  output logic                     hit_out
);
  import spq_pkg::*;

  logic [VALUE_BITS-1:0]    value_next;
  logic [PRIORITY_BITS-1:0] prio_next;
  logic                     match;

  assign ge = valid && (prio >= new_priority);
  assign match = valid && (value == new_value);
  assign hit_out = hit_in || match;

  always_comb begin
    value_next = value;
    prio_next = prio;
    if (op.ins) begin
      if (!ge) begin
        if (prev_ge) begin
          value_next = new_value;
          prio_next = new_priority;
        end else begin
          value_next = prev_value;
          prio_next = prev_priority;
        end
      end
    end else if (op.rem) begin
      if (hit_out) begin
        value_next = next_value;
        prio_next = next_priority;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    prio <= prio_next;
  end

endmodule

// File: sim/queue_checker.sv
`timescale 1ns / 1ps

module queue_checker (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_tready,
  // item_value, item_priority
  input  logic [23:0] s_tdata,
  // cmd
  input  logic [spq_pkg::CMD_W-1:0] s_tuser,
  input  logic m_tvalid,
  input  logic m_tready,
  // removed_value, head_value, entry_count, queue_empty
  input  logic [39:0] m_tdata,
  // status
  input  logic [spq_pkg::STATUS_W-1:0] m_tuser,
  output int failures,
  output int pending,
  output int words_checked
);
  import spq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int VB = VALUE_BITS_DEF;
  localparam int PB = PRIORITY_BITS_DEF;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [VB-1:0] removed_value;
    logic [VB-1:0] head_value;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0] entry_count;
    logic queue_empty;
  } queue_word_t;

  logic [VB-1:0] held_values [DEPTH];
  logic [PB-1:0] held_priorities [DEPTH];
  int held_count;
  queue_word_t awaited_words [$];

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < held_count; i++) begin
      held_values[i] = held_values[i + 1];
      held_priorities[i] = held_priorities[i + 1];
    end
    held_count--;
  endfunction

  // lands behind every entry of equal or higher priority
  function automatic bit insert_entry(logic [VB-1:0] v, logic [PB-1:0] p);
    int pos;
    if (held_count >= DEPTH) return 1'b0;
    pos = 0;
    while (pos < held_count && held_priorities[pos] >= p) pos++;
    for (int i = held_count; i > pos; i--) begin
      held_values[i] = held_values[i - 1];
      held_priorities[i] = held_priorities[i - 1];
    end
    held_values[pos] = v;
    held_priorities[pos] = p;
    held_count++;
    return 1'b1;
  endfunction

  function automatic queue_word_t serve_command(logic [CMD_W-1:0] cmd, logic [VB-1:0] v,
                                                logic [PB-1:0] p);
    queue_word_t w;
    int hit;
    w = '0;
    w.status = STATUS_OK;
    case (cmd)
      CMD_ENQUEUE: begin
        if (!insert_entry(v, p)) w.status = STATUS_FULL;
      end
      CMD_DEQUEUE: begin
        if (held_count == 0) begin
          w.status = STATUS_EMPTY;
        end else begin
          w.removed_value = held_values[0];
          drop_entry(0);
        end
      end
      CMD_CHANGE: begin
        hit = -1;
        for (int i = held_count - 1; i >= 0; i--) if (held_values[i] == v) hit = i;
        if (hit < 0) begin
          w.status = STATUS_NOT_FOUND;
        end else begin
          drop_entry(hit);
          void'(insert_entry(v, p));
        end
      end
      default: ;
    endcase
    w.head_value = (held_count > 0) ? held_values[0] : '0;
    w.entry_count = CNT_W'(held_count);
    w.queue_empty = (held_count == 0);
    return w;
  endfunction

  always @(posedge clk) begin : monitor
    queue_word_t seen;
    queue_word_t want;
    if (rst) begin
      held_count = 0;
      awaited_words.delete();
    end else begin
      if (s_tvalid && s_tready)
        awaited_words.push_back(serve_command(s_tuser, s_tdata[VB-1:0], s_tdata[VB+PB-1:VB]));
      if (m_tvalid && m_tready) begin
        seen.removed_value = m_tdata[VB-1:0];
        seen.head_value = m_tdata[2*VB-1:VB];
        seen.entry_count = m_tdata[2*VB+CNT_W-1:2*VB];
        seen.queue_empty = m_tdata[2*VB+CNT_W];
        seen.status = m_tuser;
        if (awaited_words.size() == 0) begin
          $error("result word with no command outstanding");
          failures++;
        end else begin
          want = awaited_words.pop_front();
          words_checked++;
          if (seen.removed_value !== want.removed_value) begin
            $error("removed_value: expected %h, actual %h", want.removed_value,
                   seen.removed_value);
            failures++;
          end
          if (seen.head_value !== want.head_value) begin
            $error("head_value: expected %h, actual %h", want.head_value, seen.head_value);
            failures++;
          end
          if (seen.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, seen.status);
            failures++;
          end
          if (seen.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count,
                   seen.entry_count);
            failures++;
          end
          if (seen.queue_empty !== want.queue_empty) begin
            $error("queue_empty: expected %b, actual %b", want.queue_empty,
                   seen.queue_empty);
            failures++;
          end
        end
      end
    end
    pending = awaited_words.size();
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int VB = VALUE_BITS_DEF;
  localparam int PB = PRIORITY_BITS_DEF;
  localparam int IN_W = ((VB + PB + 7) / 8) * 8;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int LIMIT = 300000;
  localparam int MODE_FILL = 0;
  localparam int MODE_DRAIN = 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [CMD_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [STATUS_W-1:0] m_tuser;

  int idle_pct = 0;
  int stall_pct = 0;
  int failures, pending, words_checked;
  int cycles = 0;
  int sent_by_cmd [4];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  sorted_priority_queue uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  queue_checker check_unit (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .failures(failures), .pending(pending), .words_checked(words_checked)
  );

  always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [VB-1:0] v,
                           input logic [PB-1:0] p);
    logic rdy;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_W'({p, v});
    s_tuser <= cmd;
    sent_by_cmd[cmd]++;
    do begin
      @(negedge clk);
      rdy = s_tready;
      @(posedge clk);
    end while (!rdy);
  endtask

  // returns at a falling edge once every result word is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  function automatic logic [CMD_W-1:0] pick_cmd(int mode);
    int r;
    r = $urandom_range(99);
    if (r < 3) return CMD_UNUSED;
    case (mode)
      MODE_FILL: return (r < 73) ? CMD_ENQUEUE : (r < 88) ? CMD_DEQUEUE : CMD_CHANGE;
      MODE_DRAIN: return (r < 18) ? CMD_ENQUEUE : (r < 88) ? CMD_DEQUEUE : CMD_CHANGE;
      default: return (r < 43) ? CMD_ENQUEUE : (r < 73) ? CMD_DEQUEUE : CMD_CHANGE;
    endcase
  endfunction

  // small pools give duplicate values and tied priorities
  function automatic logic [VB-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 60) return VB'($urandom_range(15));
    if (r < 70) return $urandom_range(1) ? '1 : '0;
    return VB'($urandom);
  endfunction

  function automatic logic [PB-1:0] pick_priority();
    int r;
    r = $urandom_range(99);
    if (r < 50) return PB'($urandom_range(3));
    if (r < 65) return $urandom_range(1) ? '1 : '0;
    return PB'($urandom);
  endfunction

  initial begin
    int sent;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_word(CMD_DEQUEUE, 16'h0000, 8'h00);
    send_word(CMD_CHANGE, 16'h0005, 8'h09);
    send_word(CMD_UNUSED, 16'hffff, 8'hff);
    send_word(CMD_ENQUEUE, 16'h0000, 8'h00);
    send_word(CMD_ENQUEUE, 16'hffff, 8'hff);
    send_word(CMD_ENQUEUE, 16'h1234, 8'hff);
    send_word(CMD_ENQUEUE, 16'haaaa, 8'h00);
    send_word(CMD_ENQUEUE, 16'h5555, 8'h80);
    send_word(CMD_ENQUEUE, 16'h1234, 8'h80);
    send_word(CMD_CHANGE, 16'h0000, 8'hff);
    send_word(CMD_CHANGE, 16'h1234, 8'h01);
    send_word(CMD_CHANGE, 16'h7777, 8'h01);
    send_word(CMD_UNUSED, 16'h0000, 8'h00);
    repeat (7) send_word(CMD_DEQUEUE, 16'h0000, 8'h00);
    repeat (16) send_word(CMD_ENQUEUE, pick_value(), pick_priority());
    send_word(CMD_ENQUEUE, 16'hbeef, 8'hff);
    send_word(CMD_CHANGE, 16'hbeef, 8'h10);
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 28 : (ph == 1) ? 63 : 0;
      stall_pct = (ph == 0) ? 63 : (ph == 1) ? 28 : 0;
      @(posedge clk);
      sent = 0;
      while (sent < 500) begin
        automatic int mode = $urandom_range(2);
        repeat ($urandom_range(40, 20)) begin
          send_word(pick_cmd(mode), pick_value(), pick_priority());
          sent++;
        end
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    $display("%0d enqueue, %0d dequeue, %0d change priority and %0d unused-code commands",
             sent_by_cmd[CMD_ENQUEUE], sent_by_cmd[CMD_DEQUEUE], sent_by_cmd[CMD_CHANGE],
             sent_by_cmd[CMD_UNUSED]);
    $display("%0d result words checked under receiver-heavy, sender-heavy and free flow",
             words_checked);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
sim/queue_checker.sv
sim/testbench.sv
